// ===== rtl/lge_pkg.sv =====
`timescale 1ns / 1ps

package lge_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  // row counter that runs a few rows past the grid during an advance
  localparam int ROW_CW = $clog2(MAX_ROWS + 4);

  localparam int CMD_W  = 2;
  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int CFG_W  = 7;
  localparam int CFG_AW = 3;
  localparam int DATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2
  } cmd_t;

  typedef enum logic {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE_RD,
    ST_WRITE_WB,
    ST_READ_RD,
    ST_READ_WB,
    ST_FILL0,
    ST_FILL1,
    ST_FILL2,
    ST_ROW
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic adv_start;
    logic rd_adv;
    logic shift_win;
    logic wr_cell;
    logic wr_adv;
    logic out_load;
    logic out_read;
  } ctl_t;

  typedef struct packed {
    logic last_row;
  } stat_t;

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                   input int max_v);
    logic [CFG_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_W'(1);
    end else if (int'(v) > max_v) begin
      res = CFG_W'(max_v);
    end
    return res;
  endfunction

  localparam logic [CFG_W-1:0] ROWS_RESET = clamp_size(7'd64, MAX_ROWS);
  localparam logic [CFG_W-1:0] COLS_RESET = clamp_size(7'd64, MAX_COLS);

endpackage

// ===== rtl/lge_ifs.sv =====
`timescale 1ns / 1ps

interface lge_in_if;
  logic                       valid;
  logic                       ready;
  logic [lge_pkg::CMD_W-1:0]  command;
  logic [lge_pkg::ROW_W-1:0]  cell_row;
  logic [lge_pkg::COL_W-1:0]  cell_col;
  logic                       cell_live;

  modport source (output valid, command, cell_row, cell_col, cell_live, input ready);
  modport sink   (input valid, command, cell_row, cell_col, cell_live, output ready);
endinterface

interface lge_out_if;
  logic valid;
  logic ready;
  logic cell_value;

  modport source (output valid, cell_value, input ready);
  modport sink   (input valid, cell_value, output ready);
endinterface

// ===== rtl/lge_ram.sv =====
`timescale 1ns / 1ps

module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lge_ctrl.sv =====
`timescale 1ns / 1ps

module lge_ctrl import lge_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [CMD_W-1:0]   in_command,
  input  logic               out_ready,
  input  stat_t              stat,
  output logic               in_ready,
  output logic               out_valid,
  output ctl_t               ctl
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  cmd_t   cmd;

  assign cmd       = cmd_t'(in_command);
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_WRITE:   state_nxt = ST_WRITE_RD;
            CMD_READ:    state_nxt = ST_READ_RD;
            CMD_ADVANCE: state_nxt = ST_FILL0;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE_RD: state_nxt = ST_WRITE_WB;
      ST_WRITE_WB: state_nxt = ST_IDLE;
      ST_READ_RD:  state_nxt = ST_READ_WB;
      ST_READ_WB:  state_nxt = ST_IDLE;
      ST_FILL0:    state_nxt = ST_FILL1;
      ST_FILL1:    state_nxt = ST_FILL2;
      ST_FILL2:    state_nxt = ST_ROW;
      ST_ROW: begin
        if (stat.last_row) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.latch_item = accept;
        ctl.adv_start  = accept && (cmd == CMD_ADVANCE);
        // unused command code finishes at once with a zero result
        ctl.out_load   = accept && (cmd != CMD_WRITE) && (cmd != CMD_READ) &&
                         (cmd != CMD_ADVANCE);
      end
      ST_WRITE_WB: begin
        ctl.wr_cell  = 1'b1;
        ctl.out_load = 1'b1;
      end
      ST_READ_WB: begin
        ctl.out_load = 1'b1;
        ctl.out_read = 1'b1;
      end
      ST_FILL0: ctl.rd_adv = 1'b1;
      ST_FILL1, ST_FILL2: begin
        ctl.rd_adv    = 1'b1;
        ctl.shift_win = 1'b1;
      end
      ST_ROW: begin
        ctl.rd_adv    = 1'b1;
        ctl.shift_win = 1'b1;
        ctl.wr_adv    = 1'b1;
        ctl.out_load  = stat.last_row;
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/lge_datapath.sv =====
`timescale 1ns / 1ps

module lge_datapath import lge_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctl_t                ctl,
  output stat_t               stat,
  input  logic [ROW_W-1:0]    in_cell_row,
  input  logic [COL_W-1:0]    in_cell_col,
  input  logic                in_cell_live,
  input  logic [CFG_W-1:0]    rows,
  input  logic [CFG_W-1:0]    cols,
  output logic                ram_we,
  output logic [ROW_AW-1:0]   ram_waddr,
  output logic [MAX_COLS-1:0] ram_wdata,
  output logic [ROW_AW-1:0]   ram_raddr,
  input  logic [MAX_COLS-1:0] ram_rdata,
  output logic                out_cell_value
);

  logic [ROW_W-1:0]    item_row_r;
  logic [COL_W-1:0]    item_col_r;
  logic                item_live_r;
  logic [ROW_CW-1:0]   issue_row_r, issue_row_nxt;
  logic [ROW_CW-1:0]   data_row_r;
  logic [ROW_AW-1:0]   comp_row_r, comp_row_nxt;
  logic [MAX_COLS-1:0] win_r [3];
  logic [MAX_COLS-1:0] win_nxt [3];
  logic [MAX_ROWS-1:0] row_valid_r, row_valid_nxt;
  logic                out_value_r, out_value_nxt;

  logic [ROW_AW-1:0]   item_row_idx;
  logic [COL_AW-1:0]   item_col_idx;
  logic                item_inside;
  logic [MAX_COLS-1:0] cell_old;
  logic [MAX_COLS-1:0] cell_new;
  logic [MAX_COLS-1:0] loaded;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] lft [3];
  logic [MAX_COLS-1:0] rgt [3];
  logic [3:0]          ncount;

  assign item_row_idx = ROW_AW'(item_row_r);
  assign item_col_idx = COL_AW'(item_col_r);
  assign item_inside  = (int'(item_row_r) < MAX_ROWS) && (int'(item_col_r) < MAX_COLS);

  // a row never written since reset reads as all dead
  assign cell_old = row_valid_r[item_row_idx] ? ram_rdata : '0;
  assign loaded   = ((int'(data_row_r) < int'(rows)) &&
                     row_valid_r[data_row_r[ROW_AW-1:0]]) ? ram_rdata : '0;

  always_comb begin
    cell_new = cell_old;
    cell_new[item_col_idx] = item_live_r;
  end

  // all columns of one row in parallel, from the three old rows in the window
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (c < int'(cols));
    end
    for (int s = 0; s < 3; s++) begin
      lft[s] = win_r[s] << 1;
      rgt[s] = (win_r[s] & col_mask) >> 1;
    end
    next_row = '0;
    for (int c = 0; c < MAX_COLS; c++) begin
      ncount = 4'(lft[0][c]) + 4'(win_r[0][c]) + 4'(rgt[0][c]) +
               4'(lft[1][c]) + 4'(rgt[1][c]) +
               4'(lft[2][c]) + 4'(win_r[2][c]) + 4'(rgt[2][c]);
      if (!col_mask[c]) begin
        next_row[c] = win_r[1][c];
      end else begin
        next_row[c] = (ncount == 4'd3) || ((ncount == 4'd2) && win_r[1][c]);
      end
    end
  end

  assign stat.last_row = (int'(comp_row_r) == int'(rows) - 1);

  assign ram_raddr = ctl.rd_adv ? issue_row_r[ROW_AW-1:0] : item_row_idx;
  assign ram_we    = ctl.wr_adv || (ctl.wr_cell && item_inside);
  assign ram_waddr = ctl.wr_adv ? comp_row_r : item_row_idx;
  assign ram_wdata = ctl.wr_adv ? next_row : cell_new;

  always_comb begin
    issue_row_nxt = issue_row_r;
    comp_row_nxt  = comp_row_r;
    win_nxt       = win_r;
    row_valid_nxt = row_valid_r;
    out_value_nxt = out_value_r;
    if (ctl.adv_start) begin
      issue_row_nxt = '0;
      comp_row_nxt  = '0;
      for (int s = 0; s < 3; s++) begin
        win_nxt[s] = '0;
      end
    end
    if (ctl.rd_adv) begin
      issue_row_nxt = issue_row_r + ROW_CW'(1);
    end
    if (ctl.shift_win) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      win_nxt[2] = loaded;
    end
    if (ctl.wr_adv) begin
      comp_row_nxt = comp_row_r + ROW_AW'(1);
    end
    if (ram_we) begin
      row_valid_nxt[ram_waddr] = 1'b1;
    end
    if (ctl.out_load) begin
      out_value_nxt = ctl.out_read && item_inside && cell_old[item_col_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch_item) begin
      item_row_r  <= in_cell_row;
      item_col_r  <= in_cell_col;
      item_live_r <= in_cell_live;
    end
    issue_row_r <= issue_row_nxt;
    data_row_r  <= issue_row_r;
    comp_row_r  <= comp_row_nxt;
    win_r       <= win_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_cell_value = out_value_r;

endmodule

// ===== rtl/life_generation_engine_core.sv =====
`timescale 1ns / 1ps
// write and read commands: a read state, then a write-back state that loads the result; a new command is
// taken only back in idle; advance: the fill states prime the three-row window, then
//   one grid row per cycle through the three-row window and row memory
// reset: synchronous active low; per-row valid bits make the whole grid read dead at once,
//   both size registers return to 64, no clearing pass

module life_generation_engine_core import lge_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  lge_in_if.sink            in_ch,
  lge_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0]    rows_r, rows_nxt;
  logic [CFG_W-1:0]    cols_r, cols_nxt;
  reg_idx_t            reg_sel;
  logic                cfg_wr;

  ctl_t                ctl;
  stat_t               stat;
  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [ROW_AW-1:0]   ram_raddr;
  logic [MAX_COLS-1:0] ram_rdata;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROWS: rows_nxt = clamp_size(pwdata[CFG_W-1:0], MAX_ROWS);
        REG_COLS: cols_nxt = clamp_size(pwdata[CFG_W-1:0], MAX_COLS);
        default:  rows_nxt = rows_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROWS: prdata = DATA_W'(rows_r);
      REG_COLS: prdata = DATA_W'(cols_r);
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RESET;
      cols_r <= COLS_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  lge_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .ctl        (ctl)
  );

  lge_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_cell_row    (in_ch.cell_row),
    .in_cell_col    (in_ch.cell_col),
    .in_cell_live   (in_ch.cell_live),
    .rows           (rows_r),
    .cols           (cols_r),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_cell_value (out_ch.cell_value)
  );

  lge_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // a new transfer in never finds the result register still occupied
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (!out_ch.valid || out_ch.ready))
    else $error("input taken while result register full");

  // a read command blocks the input and delivers its result after the read and write-back states
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.command == CMD_READ)) |=> !in_ch.ready)
    else $error("input ready during cell read");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.command == CMD_READ)) |-> ##3 out_ch.valid)
    else $error("read result missing");

  // size registers always hold a usable size
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rows_r != '0) && (int'(rows_r) <= MAX_ROWS) &&
    (cols_r != '0) && (int'(cols_r) <= MAX_COLS))
    else $error("grid size register out of range");
`endif

endmodule
